FILE: src/idll_pkg.sv
// ----------------------------------------------------------------------------
// idll_pkg
// Shared types, constants and helpers of the indexed doubly linked list core.
// ----------------------------------------------------------------------------
`default_nettype none

package idll_pkg;

	// entry table geometry
	localparam int NUM_ENTRIES = 1024;
	localparam int IDX_W       = $clog2(NUM_ENTRIES);

	// fixed field widths
	localparam int ACT_W  = 3;
	localparam int NODE_W = 10;
	localparam int ST_W   = 2;
	localparam int CNT_W  = 11;
	localparam int LINK_W = 11;

	// link value of an unlinked entry
	localparam logic [LINK_W-1:0] LINK_NONE = '1;

	typedef enum logic [ACT_W-1:0] {
		ACT_INS_AFTER = 3'd0,
		ACT_INS_HEAD  = 3'd1,
		ACT_INS_TAIL  = 3'd2,
		ACT_REM       = 3'd3,
		ACT_REM_HEAD  = 3'd4,
		ACT_REM_TAIL  = 3'd5
	} action_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_BAD   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CHECK,
		S_WRITE2
	} state_t;

	// request payload
	typedef struct packed {
		logic [ACT_W-1:0]  action;
		logic [NODE_W-1:0] node_index;
		logic [NODE_W-1:0] after_index;
	} req_t;

	// result payload
	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [NODE_W-1:0] removed_index;
		logic [CNT_W-1:0]  element_count;
	} rsp_t;

	// one memory write port
	typedef struct packed {
		logic              en;
		logic [IDX_W-1:0]  addr;
		logic [LINK_W-1:0] data;
	} wr_t;

	// shared read port of both link memories
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] addr;
	} rd_t;

	// a link or index that names a real entry
	function automatic logic link_ok(input logic [LINK_W-1:0] v);
		return 32'(v) < 32'(NUM_ENTRIES);
	endfunction

endpackage

`default_nettype wire

FILE: src/idll_ram.sv
// ----------------------------------------------------------------------------
// idll_ram
// Simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 11
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: src/idll_seq.sv
// ----------------------------------------------------------------------------
// idll_seq
// Request sequencer: operand fetch, checks, link writes in S_CHECK and S_WRITE2, count.
// ----------------------------------------------------------------------------
`default_nettype none

module idll_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire idll_pkg::req_t              req,
	output logic                             done,
	output idll_pkg::rsp_t                   rsp,
	input  wire logic                        cnt_clr,
	input  wire logic [idll_pkg::LINK_W-1:0] sentinel,
	input  wire logic [idll_pkg::LINK_W-1:0] head,
	input  wire logic [idll_pkg::LINK_W-1:0] tail,
	output idll_pkg::rd_t                    rd,
	input  wire logic [idll_pkg::LINK_W-1:0] nxt_rd,
	input  wire logic [idll_pkg::LINK_W-1:0] prv_rd,
	output idll_pkg::wr_t                    nxt_wr,
	output idll_pkg::wr_t                    prv_wr
);

	import idll_pkg::*;

	state_t            state_q, state_d;
	logic              accept;
	logic [LINK_W-1:0] opnd;
	logic [ACT_W-1:0]  act_s1;
	logic [LINK_W-1:0] node_s1;
	logic [LINK_W-1:0] opnd_s1;
	logic [LINK_W-1:0] nxt_s2;
	logic              is_ins, is_rem;
	logic              ins_bad, rem_empty, rem_bad;
	logic              chk_fail;
	status_t           fail_st;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  count_new;
	logic              done_q;
	rsp_t              rsp_q;

	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// operand whose links are fetched: insert point or entry to remove
	always_comb begin
		unique case (req.action)
			ACT_INS_AFTER: opnd = LINK_W'(req.after_index);
			ACT_INS_HEAD:  opnd = sentinel;
			ACT_INS_TAIL:  opnd = tail;
			ACT_REM:       opnd = LINK_W'(req.node_index);
			ACT_REM_HEAD:  opnd = head;
			ACT_REM_TAIL:  opnd = tail;
			default:       opnd = '0;
		endcase
	end

	assign rd.en   = accept;
	assign rd.addr = opnd[IDX_W-1:0];

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1 <= req.action;
			opnd_s1 <= opnd;
			if (req.action == ACT_REM_HEAD || req.action == ACT_REM_TAIL) begin
				node_s1 <= opnd;
			end else begin
				node_s1 <= LINK_W'(req.node_index);
			end
		end
	end

	// checks on the fetched links
	assign is_ins = (act_s1 == ACT_INS_AFTER) || (act_s1 == ACT_INS_HEAD)
		|| (act_s1 == ACT_INS_TAIL);
	assign is_rem = (act_s1 == ACT_REM) || (act_s1 == ACT_REM_HEAD)
		|| (act_s1 == ACT_REM_TAIL);
	assign ins_bad = !link_ok(node_s1) || !link_ok(opnd_s1) || (node_s1 == sentinel)
		|| (node_s1 == opnd_s1) || !link_ok(nxt_rd);
	assign rem_empty = (count_q == '0);
	assign rem_bad   = !link_ok(node_s1) || (node_s1 == sentinel)
		|| !link_ok(prv_rd) || !link_ok(nxt_rd);

	always_comb begin
		priority if (is_ins) begin
			chk_fail = ins_bad;
			fail_st  = ST_BAD;
		end else if (is_rem) begin
			chk_fail = rem_empty || rem_bad;
			fail_st  = rem_empty ? ST_EMPTY : ST_BAD;
		end else begin
			chk_fail = 1'b1;
			fail_st  = ST_BAD;
		end
	end

	// successor kept for the second write cycle
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK) begin
			nxt_s2 <= nxt_rd;
		end
	end

	// count after a successful request
	always_comb begin
		if (is_ins) begin
			count_new = (32'(count_q) < 32'(NUM_ENTRIES)) ? count_q + 1'b1 : count_q;
		end else begin
			count_new = count_q - 1'b1;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and link writes
	always_comb begin
		state_d = state_q;
		nxt_wr  = '0;
		prv_wr  = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (chk_fail) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_WRITE2;
					nxt_wr.en = 1'b1;
					prv_wr.en = 1'b1;
					if (is_ins) begin
						// new entry points at its neighbors
						nxt_wr.addr = node_s1[IDX_W-1:0];
						nxt_wr.data = nxt_rd;
						prv_wr.addr = node_s1[IDX_W-1:0];
						prv_wr.data = opnd_s1;
					end else begin
						// neighbors bypass the removed entry
						nxt_wr.addr = prv_rd[IDX_W-1:0];
						nxt_wr.data = nxt_rd;
						prv_wr.addr = nxt_rd[IDX_W-1:0];
						prv_wr.data = prv_rd;
					end
				end
			end
			S_WRITE2: begin
				state_d   = S_IDLE;
				nxt_wr.en = 1'b1;
				prv_wr.en = 1'b1;
				if (is_ins) begin
					// neighbors point at the new entry
					nxt_wr.addr = opnd_s1[IDX_W-1:0];
					nxt_wr.data = node_s1;
					prv_wr.addr = nxt_s2[IDX_W-1:0];
					prv_wr.data = node_s1;
				end else begin
					// removed entry gets invalid links
					nxt_wr.addr = node_s1[IDX_W-1:0];
					nxt_wr.data = LINK_NONE;
					prv_wr.addr = node_s1[IDX_W-1:0];
					prv_wr.data = LINK_NONE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cnt_clr) begin
			count_q <= '0;
		end else if (state_q == S_WRITE2) begin
			count_q <= count_new;
		end
	end

	// result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ((state_q == S_CHECK) && chk_fail) || (state_q == S_WRITE2);
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_CHECK && chk_fail) begin
			rsp_q.status        <= fail_st;
			rsp_q.removed_index <= '0;
			rsp_q.element_count <= count_q;
		end else if (state_q == S_WRITE2) begin
			rsp_q.status        <= ST_OK;
			rsp_q.removed_index <= is_ins ? '0 : node_s1[NODE_W-1:0];
			rsp_q.element_count <= count_new;
		end
	end

endmodule

`default_nettype wire

FILE: src/indexed_doubly_linked_list_core.sv
// ----------------------------------------------------------------------------
// indexed_doubly_linked_list_core
// Circular doubly linked list over entry indices with a sentinel entry,
// links held in next and prev RAMs.
// ----------------------------------------------------------------------------
//
//   channel   handshake          payload
//   request   start / busy       req  (action, node_index, after_index)
//   result    done (strobe)      rsp  (status, removed_index, element_count)
//   config    cfg_valid/ready    cfg_data (sentinel index)
//
// A request is fetched from both link RAMs on the accept edge, checked in
// the next cycle and written back in S_CHECK and S_WRITE2; the result
// strobe is registered after S_WRITE2 when it succeeds, after S_CHECK when
// it is rejected. The single write port of each RAM splits the write-back.
// A new request is taken in the cycle the result is shown. Reset leaves
// entry 0 as the sentinel with an empty list; no clearing pass runs. A
// sentinel change stores the old sentinel links into the RAMs in the cycle
// it is taken. The receiver cannot stall results.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_doubly_linked_list_core (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	output logic                             busy,
	input  wire idll_pkg::req_t              req,
	output logic                             done,
	output idll_pkg::rsp_t                   rsp,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [idll_pkg::NODE_W-1:0] cfg_data
);

	import idll_pkg::*;

	logic [LINK_W-1:0] sentinel_q;
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] tail_q;
	logic [LINK_W-1:0] cfg_val;
	logic              cfg_we;
	logic              cfg_take;
	logic              hit_q;
	rd_t               rd;
	wr_t               nxt_wr, prv_wr;
	wr_t               nxt_port, prv_port;
	logic [LINK_W-1:0] nxt_mem, prv_mem;
	logic [LINK_W-1:0] nxt_rd, prv_rd;

	// config request handshake
	assign cfg_ready = !busy;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign cfg_val   = LINK_W'(cfg_data);
	assign cfg_take  = cfg_we && link_ok(cfg_val);

	// sentinel and its links mirrored in registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sentinel_q <= '0;
			head_q     <= '0;
			tail_q     <= '0;
		end else if (cfg_take) begin
			sentinel_q <= cfg_val;
			head_q     <= cfg_val;
			tail_q     <= cfg_val;
		end else begin
			if (nxt_wr.en && nxt_wr.addr == sentinel_q[IDX_W-1:0]) begin
				head_q <= nxt_wr.data;
			end
			if (prv_wr.en && prv_wr.addr == sentinel_q[IDX_W-1:0]) begin
				tail_q <= prv_wr.data;
			end
		end
	end

	// old sentinel links go back to the tables when the sentinel moves
	always_comb begin
		nxt_port = nxt_wr;
		prv_port = prv_wr;
		if (cfg_take) begin
			nxt_port.en   = 1'b1;
			nxt_port.addr = sentinel_q[IDX_W-1:0];
			nxt_port.data = head_q;
			prv_port.en   = 1'b1;
			prv_port.addr = sentinel_q[IDX_W-1:0];
			prv_port.data = tail_q;
		end
	end

	// reads of the sentinel take the mirrored links
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (rd.en) begin
			hit_q <= (rd.addr == sentinel_q[IDX_W-1:0]);
		end
	end

	assign nxt_rd = hit_q ? head_q : nxt_mem;
	assign prv_rd = hit_q ? tail_q : prv_mem;

	// next link table
	idll_ram #(
		.DEPTH(NUM_ENTRIES),
		.WIDTH(LINK_W)
	) u_next_ram (
		.clk   (clk),
		.we    (nxt_port.en),
		.waddr (nxt_port.addr),
		.wdata (nxt_port.data),
		.re    (rd.en),
		.raddr (rd.addr),
		.rdata (nxt_mem)
	);

	// prev link table
	idll_ram #(
		.DEPTH(NUM_ENTRIES),
		.WIDTH(LINK_W)
	) u_prev_ram (
		.clk   (clk),
		.we    (prv_port.en),
		.waddr (prv_port.addr),
		.wdata (prv_port.data),
		.re    (rd.en),
		.raddr (rd.addr),
		.rdata (prv_mem)
	);

	// request sequencer
	idll_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.req      (req),
		.done     (done),
		.rsp      (rsp),
		.cnt_clr  (cfg_take),
		.sentinel (sentinel_q),
		.head     (head_q),
		.tail     (tail_q),
		.rd       (rd),
		.nxt_rd   (nxt_rd),
		.prv_rd   (prv_rd),
		.nxt_wr   (nxt_wr),
		.prv_wr   (prv_wr)
	);

endmodule

`default_nettype wire
